### rtl/core/assert_macros.svh
// Assertion macros shared by the lock controller RTL.
// Depends on nothing; define SYNTH to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define CLC_ASSERT_IMPL(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("%m: check failed");
`define CLC_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("%m: check failed");
`else
`define CLC_ASSERT_IMPL(lbl, ck, rstn, ante, cons)
`define CLC_ASSERT_NEXT(lbl, ck, rstn, ante, cons)
`endif

`endif

### rtl/core/clc_pkg.sv
// Shared types, constants and keyword tables of the code lock controller.
// No dependencies.
`timescale 1ns / 1ps
package clc_pkg;

	localparam int LINE_BUFFER_DEPTH_DEF = 64;
	localparam int CODE_LENGTH_DEF       = 6;

	localparam int          CAPTURE_START = 16;
	localparam logic [7:0]  NEWLINE_CHAR  = 8'h0A;
	localparam int          KW_UNLOCK_LEN = 6;
	localparam int          KW_LOCK_LEN   = 4;
	localparam int          KW_CHANGE_LEN = 15;

	typedef enum logic [2:0] {
		EV_NONE       = 3'd0,
		EV_UNLOCKED   = 3'd1,
		EV_LOCKED     = 3'd2,
		EV_CHANGED    = 3'd3,
		EV_WRONG_CODE = 3'd4,
		EV_INVALID    = 3'd5
	} clc_event_t;

	typedef enum logic [1:0] {
		CMD_UNLOCK  = 2'd0,
		CMD_LOCK    = 2'd1,
		CMD_CHANGE  = 2'd2,
		CMD_INVALID = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		logic      fire;
		cmd_kind_t kind;
	} line_cmd_t;

	typedef struct packed {
		logic done;
		logic match;
	} code_res_t;

	function automatic logic [7:0] kw_unlock_char(input logic [3:0] idx);
		case (idx)
			4'd0: kw_unlock_char = "u";
			4'd1: kw_unlock_char = "n";
			4'd2: kw_unlock_char = "l";
			4'd3: kw_unlock_char = "o";
			4'd4: kw_unlock_char = "c";
			4'd5: kw_unlock_char = "k";
			default: kw_unlock_char = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] kw_lock_char(input logic [3:0] idx);
		case (idx)
			4'd0: kw_lock_char = "l";
			4'd1: kw_lock_char = "o";
			4'd2: kw_lock_char = "c";
			4'd3: kw_lock_char = "k";
			default: kw_lock_char = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] kw_change_char(input logic [3:0] idx);
		case (idx)
			4'd0:  kw_change_char = "c";
			4'd1:  kw_change_char = "h";
			4'd2:  kw_change_char = "a";
			4'd3:  kw_change_char = "n";
			4'd4:  kw_change_char = "g";
			4'd5:  kw_change_char = "e";
			4'd6:  kw_change_char = "_";
			4'd7:  kw_change_char = "p";
			4'd8:  kw_change_char = "a";
			4'd9:  kw_change_char = "s";
			4'd10: kw_change_char = "s";
			4'd11: kw_change_char = "w";
			4'd12: kw_change_char = "o";
			4'd13: kw_change_char = "r";
			4'd14: kw_change_char = "d";
			default: kw_change_char = 8'h00;
		endcase
	endfunction

	function automatic logic [7:0] default_code_byte(input int unsigned idx);
		case (idx)
			0, 1, 2: default_code_byte = "2";
			3, 4, 5: default_code_byte = "7";
			default: default_code_byte = 8'h00;
		endcase
	endfunction

endpackage

### rtl/core/clc_req_if.sv
// Request channel of the lock controller: source byte and its origin.
// No dependencies.
`timescale 1ns / 1ps
interface clc_req_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] byte_value;

	modport source(output valid, func, byte_value, input ready);
	modport sink(input valid, func, byte_value, output ready);
endinterface

### rtl/core/clc_rsp_if.sv
// Result channel of the lock controller: event, lock drive, entry count.
// No dependencies.
`timescale 1ns / 1ps
interface clc_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_res;
	logic       locked;
	logic [2:0] entry_count;

	modport source(output valid, event_res, locked, entry_count, input ready);
	modport sink(input valid, event_res, locked, entry_count, output ready);
endinterface

### rtl/core/clc_code_unit.sv
// Code byte collection, stored code and the string-rule code compare.
// Depends on clc_pkg.
`timescale 1ns / 1ps
module clc_code_unit #(
	parameter int CODE_LENGTH = clc_pkg::CODE_LENGTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [7:0]                  byte_value,
	input  logic                        load_code,
	input  logic [CODE_LENGTH-1:0][7:0] new_code,
	output clc_pkg::code_res_t          res,
	output logic [2:0]                  entry_count
);
	import clc_pkg::*;

	localparam int EPW = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

	logic [EPW-1:0] pos_q;
	logic [EPW-1:0] pos_d;
	logic [7:0]     entered_q [CODE_LENGTH];
	logic [7:0]     stored_q  [CODE_LENGTH];
	logic           last;
	logic           match;

	assign last = (pos_q == EPW'(CODE_LENGTH - 1));

	always_comb begin
		logic       stop;
		logic [7:0] e;
		match = 1'b1;
		stop  = 1'b0;
		for (int i = 0; i < CODE_LENGTH; i++) begin
			e = (i == CODE_LENGTH - 1) ? byte_value : entered_q[i];
			if (!stop) begin
				if (e != stored_q[i]) begin
					match = 1'b0;
					stop  = 1'b1;
				end else if (e == 8'h00) begin
					stop = 1'b1;
				end
			end
		end
	end

	always_comb begin
		pos_d = pos_q;
		if (step) begin
			pos_d = last ? '0 : pos_q + 1'b1;
		end
	end

	assign res.done    = step && last;
	assign res.match   = match;
	assign entry_count = 3'(pos_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			for (int i = 0; i < CODE_LENGTH; i++) begin
				stored_q[i] <= default_code_byte(i);
			end
		end else begin
			pos_q <= pos_d;
			if (load_code) begin
				for (int i = 0; i < CODE_LENGTH; i++) begin
					stored_q[i] <= new_code[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CODE_LENGTH; i++) begin
			if (step && pos_q == EPW'(i)) begin
				entered_q[i] <= byte_value;
			end
		end
	end

endmodule

### rtl/core/clc_line_unit.sv
// Command line tracking: position, keyword prefix flags and new-code capture.
// Depends on clc_pkg.
`timescale 1ns / 1ps
module clc_line_unit #(
	parameter int LINE_BUFFER_DEPTH = clc_pkg::LINE_BUFFER_DEPTH_DEF,
	parameter int CODE_LENGTH       = clc_pkg::CODE_LENGTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [7:0]                  byte_value,
	output clc_pkg::line_cmd_t          cmd,
	output logic [CODE_LENGTH-1:0][7:0] new_code
);
	import clc_pkg::*;

	localparam int LPW = $clog2(LINE_BUFFER_DEPTH);
	localparam int CCW = $clog2(CODE_LENGTH + 1);

	logic [LPW-1:0] pos_q;
	logic [2:0]     flags_q;
	logic [CCW-1:0] cap_cnt_q;
	logic [7:0]     cap_q [CODE_LENGTH];

	logic           line_end;
	logic [2:0]     clr;
	logic [LPW:0]   cap_off;
	logic [LPW:0]   cap_next;
	logic           cap_hit;
	logic           is_unlock;
	logic           is_lock;
	logic           is_change;

	assign line_end = (byte_value == NEWLINE_CHAR) || (pos_q >= LPW'(LINE_BUFFER_DEPTH - 1));

	assign clr[0] = (pos_q < LPW'(KW_UNLOCK_LEN)) && (byte_value != kw_unlock_char(pos_q[3:0]));
	assign clr[1] = (pos_q < LPW'(KW_LOCK_LEN))   && (byte_value != kw_lock_char(pos_q[3:0]));
	assign clr[2] = (pos_q < LPW'(KW_CHANGE_LEN)) && (byte_value != kw_change_char(pos_q[3:0]));

	assign cap_off  = {1'b0, pos_q} - (LPW + 1)'(CAPTURE_START);
	assign cap_next = cap_off + 1'b1;
	assign cap_hit  = (pos_q >= LPW'(CAPTURE_START)) && (cap_off < (LPW + 1)'(CODE_LENGTH));

	assign is_unlock = flags_q[0] && (pos_q >= LPW'(KW_UNLOCK_LEN));
	assign is_lock   = flags_q[1] && (pos_q >= LPW'(KW_LOCK_LEN));
	assign is_change = flags_q[2] && (pos_q >= LPW'(KW_CHANGE_LEN));

	always_comb begin
		cmd.fire = step && line_end;
		if (is_unlock) begin
			cmd.kind = CMD_UNLOCK;
		end else if (is_lock) begin
			cmd.kind = CMD_LOCK;
		end else if (is_change) begin
			cmd.kind = CMD_CHANGE;
		end else begin
			cmd.kind = CMD_INVALID;
		end
	end

	always_comb begin
		logic       ended;
		logic [7:0] c;
		ended = 1'b0;
		for (int i = 0; i < CODE_LENGTH; i++) begin
			c = (!ended && (CCW'(i) < cap_cnt_q)) ? cap_q[i] : 8'h00;
			if (c == 8'h00) begin
				ended = 1'b1;
			end
			new_code[i] = c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			flags_q   <= 3'b111;
			cap_cnt_q <= '0;
		end else if (step) begin
			if (line_end) begin
				pos_q     <= '0;
				flags_q   <= 3'b111;
				cap_cnt_q <= '0;
			end else begin
				pos_q   <= pos_q + 1'b1;
				flags_q <= flags_q & ~clr;
				if (cap_hit) begin
					cap_cnt_q <= cap_next[CCW-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < CODE_LENGTH; i++) begin
			if (step && !line_end && cap_hit && cap_off == (LPW + 1)'(i)) begin
				cap_q[i] <= byte_value;
			end
		end
	end

endmodule

### rtl/core/code_lock_controller.sv
// Code lock controller top: input register, code and line units, result register.
// An accepted request passes the input register, then the result register.
// Throughput: one request per cycle while results are taken, set by the
// single-pass update between the registers; a stalled result holds one request.
// Reset: asynchronous, locked, stored code 222777, empty line and code entry.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module code_lock_controller #(
	parameter int LINE_BUFFER_DEPTH = clc_pkg::LINE_BUFFER_DEPTH_DEF,
	parameter int CODE_LENGTH       = clc_pkg::CODE_LENGTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	clc_req_if.sink   req,
	clc_rsp_if.source rsp
);
	import clc_pkg::*;

	logic       valid_s1;
	logic       func_s1;
	logic [7:0] byte_s1;

	logic       valid_s2;
	clc_event_t event_s2;
	logic       locked_s2;
	logic [2:0] count_s2;

	logic       lock_q;
	logic       lock_d;
	clc_event_t ev_d;
	logic       advance;

	line_cmd_t                   cmd;
	code_res_t                   code_res;
	logic [CODE_LENGTH-1:0][7:0] new_code;
	logic [2:0]                  entry_count;

	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	clc_code_unit #(
		.CODE_LENGTH(CODE_LENGTH)
	) u_code (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance && !func_s1),
		.byte_value (byte_s1),
		.load_code  (advance && func_s1 && cmd.fire && cmd.kind == CMD_CHANGE),
		.new_code   (new_code),
		.res        (code_res),
		.entry_count(entry_count)
	);

	clc_line_unit #(
		.LINE_BUFFER_DEPTH(LINE_BUFFER_DEPTH),
		.CODE_LENGTH      (CODE_LENGTH)
	) u_line (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance && func_s1),
		.byte_value(byte_s1),
		.cmd       (cmd),
		.new_code  (new_code)
	);

	always_comb begin
		ev_d   = EV_NONE;
		lock_d = lock_q;
		if (!func_s1) begin
			if (code_res.done) begin
				if (code_res.match) begin
					ev_d   = EV_UNLOCKED;
					lock_d = 1'b0;
				end else begin
					ev_d = EV_WRONG_CODE;
				end
			end
		end else if (cmd.fire) begin
			case (cmd.kind)
				CMD_UNLOCK: begin
					ev_d   = EV_UNLOCKED;
					lock_d = 1'b0;
				end
				CMD_LOCK: begin
					ev_d   = EV_LOCKED;
					lock_d = 1'b1;
				end
				CMD_CHANGE: begin
					ev_d = EV_CHANGED;
				end
				default: begin
					ev_d = EV_INVALID;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			lock_q   <= 1'b1;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				lock_q   <= lock_d;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_s1 <= req.func;
			byte_s1 <= req.byte_value;
		end
		if (advance) begin
			event_s2  <= ev_d;
			locked_s2 <= lock_d;
			count_s2  <= entry_count;
		end
	end

	assign rsp.valid       = valid_s2;
	assign rsp.event_res   = event_s2;
	assign rsp.locked      = locked_s2;
	assign rsp.entry_count = count_s2;

	`CLC_ASSERT_IMPL(a_unlock_opens, clk, arst_n, valid_s2 && event_s2 == EV_UNLOCKED, !locked_s2)
	`CLC_ASSERT_IMPL(a_lock_closes, clk, arst_n, valid_s2 && event_s2 == EV_LOCKED, locked_s2)
	`CLC_ASSERT_NEXT(a_stall_holds, clk, arst_n, valid_s1 && !advance, valid_s1 && $stable(byte_s1))
	`CLC_ASSERT_NEXT(a_wrong_keeps, clk, arst_n, advance && ev_d == EV_WRONG_CODE, lock_q == $past(lock_q))

endmodule
